/* rtl/arlc_pkg.sv */
// Shared types and constants for the access rights LRU cache.
// Holds the transfer structs, operation codes, FSM states and control structs.
// Depends on nothing.
package arlc_pkg;

  localparam int unsigned ENTRIES = 64;
  localparam int unsigned IDX_W = $clog2(ENTRIES);

  typedef logic [IDX_W-1:0] idx_t;

  localparam idx_t LAST_IDX = idx_t'(ENTRIES - 1);
  localparam logic [31:0] SELF_KEY = 32'hFFFF_FFFF;
  localparam logic REG_ROOT_AS_SELF = 1'b0;

  typedef enum logic [1:0] {
    OP_LOOKUP   = 2'd0,
    OP_ADD      = 2'd1,
    OP_FREE_ALL = 2'd2,
    OP_INVAL    = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] object_id;
    logic [31:0] user_pag;
    logic [31:0] user_uid;
    logic [31:0] new_rights;
    logic [31:0] ticket_expiry;
    logic [31:0] current_time;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [31:0] rights_out;
    logic        was_expired;
  } rsp_t;

  typedef struct packed {
    logic [31:0] object;
    logic [31:0] user;
    logic [31:0] rights;
    logic [31:0] expiry;
  } entry_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_APPLY,
    ST_RANK,
    ST_RANK_END,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic init_wr;
    logic load;
    logic scan_rd;
    logic apply;
    logic rank_rd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic need_rank;
    logic out_free;
  } sts_t;

endpackage

/* rtl/arlc_ctrl.sv */
// Sequencing state machine of the access rights LRU cache.
// Drives datapath commands from its status; uses arlc_pkg.
module arlc_ctrl import arlc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_stall_o,
  input  sts_t   sts_i,
  output cmd_t   cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (sts_i.cnt_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.cnt_last) state_d = ST_SCAN_END;
      end
      ST_SCAN_END: state_d = ST_APPLY;
      ST_APPLY: begin
        state_d = sts_i.need_rank ? ST_RANK : ST_DONE;
      end
      ST_RANK: begin
        if (sts_i.cnt_last) state_d = ST_RANK_END;
      end
      ST_RANK_END: state_d = ST_DONE;
      ST_DONE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_INIT: cmd_o.init_wr = 1'b1;
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_SCAN:  cmd_o.scan_rd = 1'b1;
      ST_APPLY: cmd_o.apply = 1'b1;
      ST_RANK:  cmd_o.rank_rd = 1'b1;
      ST_DONE:  cmd_o.out_load = sts_i.out_free;
      default: begin
        cmd_o      = '0;
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

/* rtl/arlc_datapath.sv */
// Entry storage, recency ranks, scan compare and result register of the cache.
// Executes commands from arlc_ctrl; uses arlc_pkg.
module arlc_datapath import arlc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cmd_t   cmd_i,
  output sts_t   sts_o,
  input  logic   root_as_self_i,
  input  req_t   in_data_i,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output rsp_t   out_data_o
);

  entry_t      ent_mem [ENTRIES];
  idx_t        rank_mem [ENTRIES];
  logic [ENTRIES-1:0] valid_q;

  idx_t        cnt_q;
  req_t        req_q;
  logic [31:0] key_q;
  logic        hit_q;
  idx_t        hit_idx_q, hit_rank_q, lru_idx_q;
  entry_t      hit_ent_q;
  logic        rd_vld_q, rk_vld_q;
  idx_t        rd_addr_q, rk_addr_q;
  idx_t        tgt_q, base_q;
  idx_t        rank_rd_q;
  entry_t      ent_rd_q;
  rsp_t        res_q, out_q;
  logic        out_vld_q;

  op_e         op;
  logic        obj_m, usr_m, ent_live, expd, need_rank;
  logic        ent_we;
  idx_t        ent_wa;
  entry_t      ent_wd;
  idx_t        rank_new;
  logic [31:0] key_in;

  assign op       = op_e'(req_q.operation);
  assign obj_m    = ent_rd_q.object == req_q.object_id;
  assign usr_m    = ent_rd_q.user == key_q;
  assign ent_live = valid_q[rd_addr_q];
  assign expd     = (hit_ent_q.expiry != 32'd0) && (hit_ent_q.expiry <= req_q.current_time);
  assign need_rank = ((op == OP_LOOKUP) && hit_q && !expd) || ((op == OP_ADD) && !hit_q);

  always_comb begin
    if (in_data_i.operation != OP_INVAL && root_as_self_i &&
        in_data_i.user_pag == 32'd0 && in_data_i.user_uid == 32'd0) begin
      key_in = SELF_KEY;
    end else begin
      key_in = in_data_i.user_pag;
    end
  end

  always_comb begin
    ent_we = 1'b0;
    ent_wa = hit_idx_q;
    ent_wd = hit_ent_q;
    if (cmd_i.apply) begin
      if (op == OP_LOOKUP && hit_q && expd) begin
        ent_we        = 1'b1;
        ent_wd.expiry = 32'd0;
      end else if (op == OP_ADD && hit_q) begin
        ent_we        = 1'b1;
        ent_wd.rights = req_q.new_rights;
        if (hit_ent_q.expiry == 32'd0) ent_wd.expiry = req_q.ticket_expiry;
      end else if (op == OP_ADD) begin
        ent_we = 1'b1;
        ent_wa = lru_idx_q;
        ent_wd = '{object: req_q.object_id, user: key_q, rights: req_q.new_rights,
                   expiry: req_q.ticket_expiry};
      end
    end
  end

  always_comb begin
    if (rk_addr_q == tgt_q) begin
      rank_new = LAST_IDX;
    end else if (rank_rd_q > base_q) begin
      rank_new = rank_rd_q - 1'b1;
    end else begin
      rank_new = rank_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) ent_mem[ent_wa] <= ent_wd;
    if (cmd_i.scan_rd) ent_rd_q <= ent_mem[cnt_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_wr) begin
      rank_mem[cnt_q] <= cnt_q;
    end else if (rk_vld_q) begin
      rank_mem[rk_addr_q] <= rank_new;
    end
    if (cmd_i.scan_rd || cmd_i.rank_rd) rank_rd_q <= rank_mem[cnt_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      valid_q   <= '0;
      rd_vld_q  <= 1'b0;
      rk_vld_q  <= 1'b0;
      hit_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_rd;
      rk_vld_q <= cmd_i.rank_rd;
      if (cmd_i.load || cmd_i.apply) begin
        cnt_q <= '0;
      end else if (cmd_i.init_wr || cmd_i.scan_rd || cmd_i.rank_rd) begin
        cnt_q <= (cnt_q == LAST_IDX) ? '0 : cnt_q + 1'b1;
      end
      if (cmd_i.load) begin
        hit_q <= 1'b0;
      end else if (rd_vld_q && ent_live && obj_m && usr_m) begin
        hit_q <= 1'b1;
      end
      if (rd_vld_q && op == OP_FREE_ALL && ent_live && obj_m) begin
        valid_q[rd_addr_q] <= 1'b0;
      end
      if (cmd_i.apply && op == OP_ADD && !hit_q) valid_q[lru_idx_q] <= 1'b1;
      if (cmd_i.apply && op == OP_INVAL && hit_q) valid_q[hit_idx_q] <= 1'b0;
      if (cmd_i.out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= cnt_q;
    rk_addr_q <= cnt_q;
    if (cmd_i.load) begin
      req_q <= in_data_i;
      key_q <= key_in;
    end
    if (rd_vld_q && ent_live && obj_m && usr_m && !hit_q) begin
      hit_idx_q  <= rd_addr_q;
      hit_ent_q  <= ent_rd_q;
      hit_rank_q <= rank_rd_q;
    end
    if (rd_vld_q && rank_rd_q == '0) lru_idx_q <= rd_addr_q;
    if (cmd_i.apply) begin
      tgt_q             <= (op == OP_LOOKUP) ? hit_idx_q : lru_idx_q;
      base_q            <= (op == OP_LOOKUP) ? hit_rank_q : '0;
      res_q.found       <= (op == OP_LOOKUP) && hit_q;
      res_q.was_expired <= (op == OP_LOOKUP) && hit_q && expd;
      res_q.rights_out  <= ((op == OP_LOOKUP) && hit_q && !expd) ? hit_ent_q.rights : 32'd0;
    end
    if (cmd_i.out_load) out_q <= res_q;
  end

  assign sts_o.cnt_last  = cnt_q == LAST_IDX;
  assign sts_o.need_rank = need_rank;
  assign sts_o.out_free  = !out_vld_q || !out_stall_i;

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/access_rights_lru_cache.sv */
// Top level of the access rights LRU cache: configuration register and wiring.
// Instantiates arlc_ctrl and arlc_datapath; uses arlc_pkg.
//
// Requests enter on in_valid_i/in_stall_o/in_data_i; one result transfer leaves
// on out_valid_o/out_stall_i/out_data_o for every request transfer.
// Each request scans all ENTRIES entries one per cycle through a single read
// port of the entry memory, then applies its update. Lookups that hit an
// unexpired entry and adds that miss also sweep the recency ranks one entry
// per cycle. The next request is taken only after the result of the last one
// is loaded into the output register, so requests do not overlap.
// After reset a clearing pass writes the initial ranks of all entries; no
// request is taken during it, while the register port works at once.
// root_as_self sits at byte address 0 and resets to one.
// A stalled result is held in the output register; a finished request waits
// there until the output register is free.
module access_rights_lru_cache import arlc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  req_t        in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output rsp_t        out_data_o
);

  logic root_as_self_q;
  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_as_self_q <= 1'b1;
    end else if (psel && penable && pwrite && paddr[2] == REG_ROOT_AS_SELF) begin
      root_as_self_q <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_ROOT_AS_SELF) ? {31'd0, root_as_self_q} : 32'd0;

  arlc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  arlc_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .root_as_self_i (root_as_self_q),
    .in_data_i      (in_data_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_data_o     (out_data_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("Request accepted while a request is in progress.");

  a_result_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.out_load))
    else $error("Result appeared without a completed request.");

  a_miss_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.found) |->
      (out_data_o.rights_out == 32'd0 && !out_data_o.was_expired))
    else $error("Miss result carries nonzero fields.");

  a_expired_has_no_rights: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.was_expired) |->
      (out_data_o.found && out_data_o.rights_out == 32'd0))
    else $error("Expired hit carries rights.");

endmodule
